### hw/rtl/cfbp_pkg.sv
// Shared constants for the code frame bit placer.
`timescale 1ns / 1ps

package cfbp_pkg;

  // Field widths of the request channels
  localparam int DATA_W     = 8;
  localparam int CFG_W      = 13;
  localparam int FRAME_IDX_W = 24;
  localparam int PIX_POS_W  = 12;
  localparam int CHAN_W     = 2;
  localparam int LEVEL_W    = 8;
  localparam int OUT_DATA_W = 64;

  // Geometry of the finder corners
  localparam int FINDER  = 8;
  localparam int DIM_MIN = 17;

  // Pixel levels
  localparam logic [LEVEL_W-1:0] LEVEL_ONE  = 8'd255;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 8'd0;

  // Configuration register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // Band codes
  localparam logic [1:0] BAND_TOP    = 2'd0;
  localparam logic [1:0] BAND_MIDDLE = 2'd1;
  localparam logic [1:0] BAND_BOTTOM = 2'd2;

  // Channel phase limits
  localparam logic [CHAN_W-1:0] CHAN_FIRST = 2'd0;
  localparam logic [CHAN_W-1:0] CHAN_LAST  = 2'd2;

endpackage

### hw/rtl/code_frame_bit_placer.sv
// Top level of the code frame bit placer: byte in, eight pixel-channel writes out.
`timescale 1ns / 1ps

// The byte is registered in the sequencer, and each of its writes then reaches out_* through the output register.
// One write per cycle while out_* is not stalled, from the single position stepping
//   unit; the next byte is taken in the cycle the eighth write is loaded.
// Output stalls hold the stepping unit; in_tready stays low while a byte is in work, until its eighth write is loaded.
// Reset (rst_n low, synchronous): position to frame 0 / row 0 / column 8 / channel 0,
//   columns 200, rows 100, no request pending.
module code_frame_bit_placer #(
  parameter int POS_BITS   = 12,
  parameter int FRAME_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [cfbp_pkg::CFG_W-1:0]        cfg_wdata,
  // input requests
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cfbp_pkg::DATA_W-1:0]       in_tdata,   // [7:0] data_byte
  // result requests
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [23:0] frame_index, [35:24] pixel_row, [47:36] pixel_column,
  // [49:48] colour_channel, [57:50] pixel_level, [63:58] zero
  output logic [cfbp_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser,  // [0] opens_frame
  output logic                              out_tlast   // last_of_byte
);

  localparam int PW  = POS_BITS + 1;
  localparam int DW  = (PW > cfbp_pkg::CFG_W) ? PW : cfbp_pkg::CFG_W;
  localparam int RW  = (POS_BITS > cfbp_pkg::PIX_POS_W) ? POS_BITS : cfbp_pkg::PIX_POS_W;
  localparam int FW  = (FRAME_BITS > cfbp_pkg::FRAME_IDX_W) ? FRAME_BITS
                                                             : cfbp_pkg::FRAME_IDX_W;
  localparam logic [DW-1:0]         DIM_MAX   = DW'(1) << POS_BITS;
  localparam logic [DW-1:0]         DIM_MIN_D = DW'(cfbp_pkg::DIM_MIN);
  localparam logic [PW-1:0]         FIND_P    = PW'(cfbp_pkg::FINDER);
  localparam logic [POS_BITS-1:0]   FIND_S    = POS_BITS'(cfbp_pkg::FINDER);
  localparam logic [FRAME_BITS-1:0] FRAME_MAX = {FRAME_BITS{1'b1}};

  // Configuration registers
  logic [cfbp_pkg::CFG_W-1:0] cfg_cols_r, cfg_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_cols_r <= cfbp_pkg::CFG_W'(200);
      cfg_rows_r <= cfbp_pkg::CFG_W'(100);
    end else if (cfg_we) begin
      case (cfg_addr)
        cfbp_pkg::REG_COLUMNS: cfg_cols_r <= cfg_wdata;
        cfbp_pkg::REG_ROWS:    cfg_rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamped dimensions and band bounds, registered
  logic [DW-1:0] cols_ext, rows_ext, cols_cl, rows_cl;
  logic [PW-1:0] cols_r, rows_r, cols_m8_r, rows_m8_r;

  always_comb begin
    cols_ext = DW'(cfg_cols_r);
    rows_ext = DW'(cfg_rows_r);
    if (cols_ext < DIM_MIN_D)    cols_cl = DIM_MIN_D;
    else if (cols_ext > DIM_MAX) cols_cl = DIM_MAX;
    else                         cols_cl = cols_ext;
    if (rows_ext < DIM_MIN_D)    rows_cl = DIM_MIN_D;
    else if (rows_ext > DIM_MAX) rows_cl = DIM_MAX;
    else                         rows_cl = rows_ext;
  end

  always_ff @(posedge clk) begin
    cols_r    <= cols_cl[PW-1:0];
    rows_r    <= rows_cl[PW-1:0];
    cols_m8_r <= cols_cl[PW-1:0] - FIND_P;
    rows_m8_r <= rows_cl[PW-1:0] - FIND_P;
  end

  // Sequencer state
  logic                           busy_r, busy_nxt;
  logic [2:0]                     bit_cnt_r, bit_cnt_nxt;
  logic [cfbp_pkg::DATA_W-1:0]    byte_r, byte_nxt;
  logic [1:0]                     band_r, band_nxt;
  logic [POS_BITS-1:0]            row_r, row_nxt;
  logic [POS_BITS-1:0]            col_r, col_nxt;
  logic [cfbp_pkg::CHAN_W-1:0]    chan_r, chan_nxt;
  logic [FRAME_BITS-1:0]          frame_r, frame_nxt;

  logic load, in_fire, last_bit;
  assign load      = busy_r && (!out_tvalid || out_tready);
  assign last_bit  = (bit_cnt_r == 3'd7);
  assign in_tready = !busy_r || (load && last_bit);
  assign in_fire   = in_tvalid && in_tready;

  // Position stepping unit: one channel step per loaded write
  logic [PW-1:0] col_inc, row_inc;

  always_comb begin
    col_inc   = PW'(col_r) + PW'(1);
    row_inc   = PW'(row_r) + PW'(1);
    band_nxt  = band_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    chan_nxt  = chan_r;
    frame_nxt = frame_r;
    if (load) begin
      if (chan_r < cfbp_pkg::CHAN_LAST) begin
        chan_nxt = chan_r + 2'd1;
      end else begin
        chan_nxt = cfbp_pkg::CHAN_FIRST;
        col_nxt  = col_inc[POS_BITS-1:0];
        case (band_r)
          cfbp_pkg::BAND_TOP: begin
            if (col_inc >= cols_m8_r) begin
              col_nxt = FIND_S;
              row_nxt = row_inc[POS_BITS-1:0];
              if (row_inc >= FIND_P) begin
                band_nxt = cfbp_pkg::BAND_MIDDLE;
                row_nxt  = FIND_S;
                col_nxt  = '0;
              end
            end
          end
          cfbp_pkg::BAND_MIDDLE: begin
            if (col_inc >= cols_r) begin
              col_nxt = '0;
              row_nxt = row_inc[POS_BITS-1:0];
              if (row_inc >= rows_m8_r) begin
                band_nxt = cfbp_pkg::BAND_BOTTOM;
                row_nxt  = rows_m8_r[POS_BITS-1:0];
                col_nxt  = FIND_S;
              end
            end
          end
          default: begin
            // bottom band, also the unused code
            if (col_inc >= cols_r) begin
              col_nxt = FIND_S;
              row_nxt = row_inc[POS_BITS-1:0];
              if (row_inc >= rows_r) begin
                band_nxt = cfbp_pkg::BAND_TOP;
                row_nxt  = '0;
                col_nxt  = FIND_S;
                if (frame_r != FRAME_MAX) frame_nxt = frame_r + FRAME_BITS'(1);
              end
            end
          end
        endcase
      end
    end
  end

  // Byte sequencing
  always_comb begin
    busy_nxt    = busy_r;
    bit_cnt_nxt = bit_cnt_r;
    byte_nxt    = byte_r;
    if (load) begin
      bit_cnt_nxt = bit_cnt_r + 3'd1;
      if (last_bit) busy_nxt = 1'b0;
    end
    if (in_fire) begin
      busy_nxt    = 1'b1;
      bit_cnt_nxt = '0;
      byte_nxt    = in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      bit_cnt_r <= '0;
      band_r    <= cfbp_pkg::BAND_TOP;
      row_r     <= '0;
      col_r     <= FIND_S;
      chan_r    <= cfbp_pkg::CHAN_FIRST;
      frame_r   <= '0;
    end else begin
      busy_r    <= busy_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      band_r    <= band_nxt;
      row_r     <= row_nxt;
      col_r     <= col_nxt;
      chan_r    <= chan_nxt;
      frame_r   <= frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [cfbp_pkg::FRAME_IDX_W-1:0] o_frame_r;
  logic [cfbp_pkg::PIX_POS_W-1:0]   o_row_r, o_col_r;
  logic [cfbp_pkg::CHAN_W-1:0]      o_chan_r;
  logic [cfbp_pkg::LEVEL_W-1:0]     o_level_r;
  logic                             o_open_r, o_last_r;
  logic [RW-1:0]                    row_wide, col_wide;
  logic [FW-1:0]                    frame_wide;
  logic                             at_start, bit_val;

  assign row_wide   = RW'(row_r);
  assign col_wide   = RW'(col_r);
  assign frame_wide = FW'(frame_r);
  assign at_start   = (band_r == cfbp_pkg::BAND_TOP) && (row_r == '0) &&
                      (col_r == FIND_S) && (chan_r == cfbp_pkg::CHAN_FIRST);
  assign bit_val    = byte_r[bit_cnt_r];

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load)            out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_frame_r <= frame_wide[cfbp_pkg::FRAME_IDX_W-1:0];
      o_row_r   <= row_wide[cfbp_pkg::PIX_POS_W-1:0];
      o_col_r   <= col_wide[cfbp_pkg::PIX_POS_W-1:0];
      o_chan_r  <= chan_r;
      o_level_r <= bit_val ? cfbp_pkg::LEVEL_ONE : cfbp_pkg::LEVEL_ZERO;
      o_open_r  <= at_start && (frame_r != '0);
      o_last_r  <= last_bit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, o_level_r, o_chan_r, o_col_r, o_row_r, o_frame_r};
  assign out_tuser  = o_open_r;
  assign out_tlast  = o_last_r;

`ifndef SYNTH
  // channel phase only runs 0..2
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    chan_r != 2'd3) else $error("channel phase left its range");

  // a new byte is taken while busy only when the eighth write is being loaded
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && busy_r) |-> (load && last_bit))
    else $error("byte taken in the middle of a byte");

  // after the eighth write with no new byte the sequencer goes idle
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_bit && !in_fire) |=> !busy_r)
    else $error("sequencer stayed busy after the eighth write");

  // the eighth write is flagged as last
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_bit) |=> (out_tvalid && out_tlast))
    else $error("eighth write not flagged as last");
`endif

endmodule

### tb/code_frame_bit_placer_test.sv
// Self-checking testbench for the code frame bit placer: directed table, then random bursts.
`timescale 1ns / 1ps

module code_frame_bit_placer_test;

  localparam int CLK_PERIOD   = 20;
  localparam int RANDOM_BYTES = 360;
  localparam int SETTLE       = 6;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int POS_LIMIT    = 1 << cfbp_pkg::PIX_POS_W;

  // One pixel-channel write as the block reports it
  typedef struct packed {
    logic [cfbp_pkg::FRAME_IDX_W-1:0] frame;
    logic [cfbp_pkg::PIX_POS_W-1:0]   row;
    logic [cfbp_pkg::PIX_POS_W-1:0]   col;
    logic [cfbp_pkg::CHAN_W-1:0]      chan;
    logic [cfbp_pkg::LEVEL_W-1:0]     level;
    logic                             opens;
    logic                             last;
  } pixel_write_t;

  typedef enum logic {ROW_DATA, ROW_CFG} row_kind_t;

  // Directed stimulus row; first_write is hand-typed where has_typed is set
  typedef struct packed {
    row_kind_t                     kind;
    logic                          addr;
    logic [cfbp_pkg::CFG_W-1:0]    value;
    logic [cfbp_pkg::DATA_W-1:0]   data;
    logic [7:0]                    reps;
    logic                          has_typed;
    pixel_write_t                  first_write;
  } stim_row_t;

  localparam int NUM_DIRECTED = 20;
  localparam pixel_write_t NO_WRITE = '0;

  logic                              clk;
  logic                              rst_n;
  logic                              cfg_we;
  logic                              cfg_addr;
  logic [cfbp_pkg::CFG_W-1:0]        cfg_wdata;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [cfbp_pkg::DATA_W-1:0]       in_tdata;    // [7:0] data_byte
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  // [23:0] frame_index, [35:24] pixel_row, [47:36] pixel_column,
  // [49:48] colour_channel, [57:50] pixel_level, [63:58] zero
  logic [cfbp_pkg::OUT_DATA_W-1:0]   out_tdata;
  logic                              out_tuser;   // [0] opens_frame
  logic                              out_tlast;   // last_of_byte

  code_frame_bit_placer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Placement state mirrored by the testbench
  logic [cfbp_pkg::CFG_W-1:0]       image_columns;
  logic [cfbp_pkg::CFG_W-1:0]       image_rows;
  logic [1:0]                       band;
  logic [31:0]                      row_pos;
  logic [31:0]                      col_pos;
  logic [cfbp_pkg::CHAN_W-1:0]      chan_ph;
  logic [cfbp_pkg::FRAME_IDX_W-1:0] frame_no;

  pixel_write_t pending_writes[$];
  stim_row_t    directed_rows [NUM_DIRECTED];

  int errors      = 0;
  int cycle_count = 0;
  int src_mode;
  int sink_mode;
  int ready_hold  = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Idle length: mostly none, some short, a few long; mode 0 never idles
  function automatic int pick_wait(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned clamp_dim(input logic [cfbp_pkg::CFG_W-1:0] v);
    if (v < cfbp_pkg::DIM_MIN) return cfbp_pkg::DIM_MIN;
    if (v > POS_LIMIT) return POS_LIMIT;
    return v;
  endfunction

  // Step channel, then column, then row through the three bands
  task automatic step_position(input int unsigned cols, input int unsigned rows);
    if (chan_ph < cfbp_pkg::CHAN_LAST) begin
      chan_ph++;
      return;
    end
    chan_ph = cfbp_pkg::CHAN_FIRST;
    col_pos++;
    case (band)
      cfbp_pkg::BAND_TOP: begin
        if (col_pos >= cols - cfbp_pkg::FINDER) begin
          col_pos = cfbp_pkg::FINDER;
          row_pos++;
          if (row_pos >= cfbp_pkg::FINDER) begin
            band    = cfbp_pkg::BAND_MIDDLE;
            row_pos = cfbp_pkg::FINDER;
            col_pos = 0;
          end
        end
      end
      cfbp_pkg::BAND_MIDDLE: begin
        if (col_pos >= cols) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= rows - cfbp_pkg::FINDER) begin
            band    = cfbp_pkg::BAND_BOTTOM;
            row_pos = rows - cfbp_pkg::FINDER;
            col_pos = cfbp_pkg::FINDER;
          end
        end
      end
      // bottom band; the unused code behaves the same
      default: begin
        if (col_pos >= cols) begin
          col_pos = cfbp_pkg::FINDER;
          row_pos++;
          if (row_pos >= rows) begin
            band    = cfbp_pkg::BAND_TOP;
            row_pos = 0;
            col_pos = cfbp_pkg::FINDER;
            if (frame_no != '1) frame_no++;
          end
        end
      end
    endcase
  endtask

  // Expected eight writes of one byte, bit 0 first
  task automatic place_byte(input logic [cfbp_pkg::DATA_W-1:0] data_byte);
    pixel_write_t w;
    int unsigned  cols;
    int unsigned  rows;
    int           i;
    cols = clamp_dim(image_columns);
    rows = clamp_dim(image_rows);
    for (i = 0; i < 8; i++) begin
      w.frame = frame_no;
      w.row   = row_pos[cfbp_pkg::PIX_POS_W-1:0];
      w.col   = col_pos[cfbp_pkg::PIX_POS_W-1:0];
      w.chan  = chan_ph;
      w.level = data_byte[i] ? cfbp_pkg::LEVEL_ONE : cfbp_pkg::LEVEL_ZERO;
      w.opens = (band == cfbp_pkg::BAND_TOP) && (row_pos == 0) &&
                (col_pos == cfbp_pkg::FINDER) &&
                (chan_ph == cfbp_pkg::CHAN_FIRST) && (frame_no != 0);
      w.last  = (i == 7);
      pending_writes = {pending_writes, w};
      step_position(cols, rows);
    end
  endtask

  // Drop valid and wait for every expected write to drain
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_register(input logic addr, input logic [cfbp_pkg::CFG_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (addr == cfbp_pkg::REG_COLUMNS) image_columns = value;
    else image_rows = value;
  endtask

  // Offer one byte, hold until taken, then predict its writes
  task automatic send_byte(input logic [cfbp_pkg::DATA_W-1:0] b, input logic has_typed,
                           input pixel_write_t typed_write);
    int gap;
    gap = pick_wait(src_mode);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    place_byte(b);
    if (has_typed) pending_writes[pending_writes.size() - 8] = typed_write;
  endtask

  task automatic check_field(input string name, input longint expv, input longint actv);
    if (expv != actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expv, actv);
      errors++;
    end
  endtask

  // Result side: random backpressure, compare, timeout
  always @(posedge clk) begin
    pixel_write_t want;
    int           w;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d writes pending", $time, pending_writes.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_writes.size() == 0) begin
          $display("%0t: unexpected write, expected none, actual tdata %h", $time, out_tdata);
          errors++;
        end else begin
          want = pending_writes.pop_front();
          check_field("frame_index", want.frame, out_tdata[23:0]);
          check_field("pixel_row", want.row, out_tdata[35:24]);
          check_field("pixel_column", want.col, out_tdata[47:36]);
          check_field("colour_channel", want.chan, out_tdata[49:48]);
          check_field("pixel_level", want.level, out_tdata[57:50]);
          check_field("pad bits", 0, out_tdata[63:58]);
          check_field("opens_frame", want.opens, out_tuser);
          check_field("last_of_byte", want.last, out_tlast);
        end
      end
      if (!rst_n) begin
        out_tready <= 1'b0;
      end else if (ready_hold > 0) begin
        ready_hold--;
        out_tready <= 1'b0;
      end else begin
        w = pick_wait(sink_mode);
        out_tready <= (w == 0);
        ready_hold = (w > 0) ? w - 1 : 0;
      end
    end
  end

  // Stimulus
  initial begin
    int k;
    int n;
    int r;
    int burst;
    int random_sent;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = cfbp_pkg::REG_COLUMNS;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    src_mode    = 1;
    sink_mode   = 1;
    random_sent = 0;

    // Reset state of the block
    image_columns = 200;
    image_rows    = 100;
    band          = cfbp_pkg::BAND_TOP;
    row_pos       = 0;
    col_pos       = cfbp_pkg::FINDER;
    chan_ph       = cfbp_pkg::CHAN_FIRST;
    frame_no      = '0;

    directed_rows = '{
      // first write after reset, all ones
      '{ROW_DATA, cfbp_pkg::REG_COLUMNS, 13'd0, 8'hFF, 8'd1, 1'b1,
        '{24'd0, 12'd0, 12'd8, cfbp_pkg::CHAN_FIRST, cfbp_pkg::LEVEL_ONE, 1'b0, 1'b0}},
      // eight channels later, all zeros
      '{ROW_DATA, cfbp_pkg::REG_COLUMNS, 13'd0, 8'h00, 8'd1, 1'b1,
        '{24'd0, 12'd0, 12'd10, cfbp_pkg::CHAN_LAST, cfbp_pkg::LEVEL_ZERO, 1'b0, 1'b0}},
      '{ROW_DATA, cfbp_pkg::REG_COLUMNS, 13'd0, 8'hA5, 8'd1, 1'b0, NO_WRITE},
      '{ROW_DATA, cfbp_pkg::REG_COLUMNS, 13'd0, 8'h5A, 8'd1, 1'b0, NO_WRITE},
      '{ROW_DATA, cfbp_pkg::REG_COLUMNS, 13'd0, 8'h01, 8'd1, 1'b0, NO_WRITE},
      '{ROW_DATA, cfbp_pkg::REG_COLUMNS, 13'd0, 8'h80, 8'd1, 1'b0, NO_WRITE},
      // shrink below minimum mid-frame: clamps to 17, position pulled back
      '{ROW_CFG, cfbp_pkg::REG_COLUMNS, 13'd0, 8'h00, 8'd0, 1'b0, NO_WRITE},
      '{ROW_CFG, cfbp_pkg::REG_ROWS, 13'd16, 8'h00, 8'd0, 1'b0, NO_WRITE},
      // enough to wrap a minimum frame and flag the next one
      '{ROW_DATA, cfbp_pkg::REG_COLUMNS, 13'd0, 8'hC3, 8'd40, 1'b0, NO_WRITE},
      '{ROW_DATA, cfbp_pkg::REG_COLUMNS, 13'd0, 8'h3C, 8'd2, 1'b0, NO_WRITE},
      // largest register values clamp to 4096
      '{ROW_CFG, cfbp_pkg::REG_COLUMNS, 13'h1FFF, 8'h00, 8'd0, 1'b0, NO_WRITE},
      '{ROW_CFG, cfbp_pkg::REG_ROWS, 13'h1FFF, 8'h00, 8'd0, 1'b0, NO_WRITE},
      '{ROW_DATA, cfbp_pkg::REG_COLUMNS, 13'd0, 8'h0F, 8'd3, 1'b0, NO_WRITE},
      '{ROW_CFG, cfbp_pkg::REG_COLUMNS, 13'd4096, 8'h00, 8'd0, 1'b0, NO_WRITE},
      '{ROW_CFG, cfbp_pkg::REG_ROWS, 13'd4096, 8'h00, 8'd0, 1'b0, NO_WRITE},
      '{ROW_DATA, cfbp_pkg::REG_COLUMNS, 13'd0, 8'hF0, 8'd3, 1'b0, NO_WRITE},
      '{ROW_CFG, cfbp_pkg::REG_COLUMNS, 13'd17, 8'h00, 8'd0, 1'b0, NO_WRITE},
      '{ROW_CFG, cfbp_pkg::REG_ROWS, 13'd17, 8'h00, 8'd0, 1'b0, NO_WRITE},
      '{ROW_DATA, cfbp_pkg::REG_COLUMNS, 13'd0, 8'h96, 8'd45, 1'b0, NO_WRITE},
      '{ROW_DATA, cfbp_pkg::REG_COLUMNS, 13'd0, 8'h69, 8'd2, 1'b0, NO_WRITE}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (k = 0; k < NUM_DIRECTED; k++) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        write_register(directed_rows[k].addr, directed_rows[k].value);
      end else begin
        for (n = 0; n < directed_rows[k].reps; n++)
          send_byte(directed_rows[k].data, directed_rows[k].has_typed && (n == 0),
                    directed_rows[k].first_write);
      end
    end

    // Random bursts, each with its own idling mix, most after a change of frame size
    while (random_sent < RANDOM_BYTES) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        write_register(cfbp_pkg::REG_COLUMNS,
                       cfbp_pkg::CFG_W'($urandom_range(cfbp_pkg::DIM_MIN, 40)));
        write_register(cfbp_pkg::REG_ROWS,
                       cfbp_pkg::CFG_W'($urandom_range(cfbp_pkg::DIM_MIN, 40)));
      end else if (r == 6) begin
        write_register(cfbp_pkg::REG_COLUMNS,
                       cfbp_pkg::CFG_W'($urandom_range(cfbp_pkg::DIM_MIN, 8191)));
      end else if (r == 7) begin
        write_register(cfbp_pkg::REG_ROWS,
                       cfbp_pkg::CFG_W'($urandom_range(cfbp_pkg::DIM_MIN, 8191)));
      end else if (r == 8) begin
        write_register(cfbp_pkg::REG_COLUMNS,
                       cfbp_pkg::CFG_W'($urandom_range(0, cfbp_pkg::DIM_MIN - 1)));
        write_register(cfbp_pkg::REG_ROWS,
                       cfbp_pkg::CFG_W'($urandom_range(POS_LIMIT, 8191)));
      end
      src_mode  = ($urandom_range(0, 3) == 0) ? 0 : 1;
      sink_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
      burst = $urandom_range(8, 50);
      for (n = 0; n < burst && random_sent < RANDOM_BYTES; n++) begin
        send_byte(cfbp_pkg::DATA_W'($urandom_range(0, 255)), 1'b0, NO_WRITE);
        random_sent++;
        // occasional hold-off until the block has drained
        if ($urandom_range(0, 29) == 0) wait_drained();
      end
    end

    // Drain and report
    in_tvalid <= 1'b0;
    sink_mode = 0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
